@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/uset_pkg.sv @@
`timescale 1ns / 1ps
package uset_pkg;

  localparam int CNT_W     = 5;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 4;
  // size and capacity are five bits wide, so no more than 31 slots are usable
  localparam int MAX_SLOTS = 31;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } uset_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } uset_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } uset_cmd_t;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

endpackage

@@ rtl/uset_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module uset_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output uset_pkg::uset_cmd_t cmd
);

  uset_pkg::uset_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      uset_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = uset_pkg::ST_EXEC;
      end
      uset_pkg::ST_EXEC: begin
        if (out_free) state_nxt = uset_pkg::ST_IDLE;
      end
      default: state_nxt = uset_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      uset_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      uset_pkg::ST_EXEC: begin
        cmd.execute = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute)     out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uset_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && !in_stall, state_r == uset_pkg::ST_EXEC, "accepted beat did not start execution")
  `ASSERT_NEXT(a_exec_loads, clk, rst_n, cmd.execute, out_valid_r, "executed beat produced no result")

endmodule

@@ rtl/uset_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module uset_dp #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  uset_pkg::uset_cmd_t         cmd,
  input  logic [1:0]                  in_cmd,
  input  logic signed [31:0]          in_value,
  input  logic                        cfg_wr_en,
  input  logic [uset_pkg::CNT_W-1:0]  cfg_wr_data,
  output logic                        out_was_present,
  output logic [uset_pkg::POS_W-1:0]  out_position,
  output logic [uset_pkg::CNT_W-1:0]  out_set_size,
  output logic                        out_stored,
  output logic                        out_rejected_full
);

  localparam int CNT_W = uset_pkg::CNT_W;
  localparam int VAL_W = uset_pkg::VAL_W;
  localparam int POS_W = uset_pkg::POS_W;
  localparam int SLOTS = (DEPTH < uset_pkg::MAX_SLOTS) ? DEPTH : uset_pkg::MAX_SLOTS;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  logic [CNT_W-1:0]     cap_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [VAL_W-1:0]     entries_r [SLOTS];
  logic [SLOTS-1:0]     hit_r, hit_nxt;
  uset_pkg::uset_op_t   op_r;
  logic [VAL_W-1:0]     value_r;

  logic                 present_r, stored_r, rejected_r;
  logic [POS_W-1:0]     position_r;
  logic [CNT_W-1:0]     size_r;

  logic [IDX_W-1:0]     slot;
  logic [CNT_W-1:0]     slot_ext;
  logic                 found;
  logic [CNT_W-1:0]     cap_eff;
  logic                 room;
  logic [CNT_W-1:0]     cnt_dec;
  logic [IDX_W-1:0]     last_idx;
  logic                 we;
  logic [IDX_W-1:0]     wr_idx;
  logic [VAL_W-1:0]     wr_data;
  logic                 present_nxt, stored_nxt, rejected_nxt;
  logic [POS_W-1:0]     position_nxt;

  // one comparator per slot, masked to the filled part of the store
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_nxt[i] = (entries_r[i] == in_value) && (CNT_W'(i) < count_r);
    end
  end

  // entries are distinct, so at most one hit and an or-tree gives its index
  always_comb begin
    slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot = slot | ({IDX_W{hit_r[i]}} & IDX_W'(i));
    end
  end

  assign found    = |hit_r;
  assign slot_ext = CNT_W'(slot);
  assign cap_eff  = (cap_r > SLOTS_C) ? SLOTS_C : cap_r;
  assign room     = count_r < cap_eff;
  assign cnt_dec  = count_r - CNT_W'(1);
  assign last_idx = cnt_dec[IDX_W-1:0];

  always_comb begin
    count_nxt    = count_r;
    we           = 1'b0;
    wr_idx       = count_r[IDX_W-1:0];
    wr_data      = value_r;
    stored_nxt   = 1'b0;
    rejected_nxt = 1'b0;
    present_nxt  = found;
    case (op_r)
      uset_pkg::OP_ADD: begin
        if (!found && room) begin
          we         = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
          stored_nxt = 1'b1;
        end else if (!found) begin
          rejected_nxt = 1'b1;
        end
      end
      uset_pkg::OP_REMOVE: begin
        // swap-remove: last entry moves into the freed slot
        if (found) begin
          we        = 1'b1;
          wr_idx    = slot;
          wr_data   = entries_r[last_idx];
          count_nxt = cnt_dec;
        end
      end
      uset_pkg::OP_QUERY: begin
        count_nxt = count_r;
      end
      uset_pkg::OP_CLEAR: begin
        count_nxt   = '0;
        present_nxt = 1'b0;
      end
      default: count_nxt = count_r;
    endcase
    position_nxt = present_nxt ? slot_ext[POS_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= uset_pkg::CAP_RESET;
      count_r <= '0;
      hit_r   <= '0;
    end else begin
      if (cfg_wr_en)   cap_r   <= cfg_wr_data;
      if (cmd.execute) count_r <= count_nxt;
      if (cmd.capture) hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= uset_pkg::uset_op_t'(in_cmd);
      value_r <= in_value;
    end
    if (cmd.execute && we) entries_r[wr_idx] <= wr_data;
    if (cmd.execute) begin
      present_r  <= present_nxt;
      position_r <= position_nxt;
      size_r     <= count_nxt;
      stored_r   <= stored_nxt;
      rejected_r <= rejected_nxt;
    end
  end

  assign out_was_present   = present_r;
  assign out_position      = position_r;
  assign out_set_size      = size_r;
  assign out_stored        = stored_r;
  assign out_rejected_full = rejected_r;

  `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, 1'b1, count_r <= SLOTS_C, "set size beyond store depth")
  `ASSERT_IMPLIES(a_hit_single, clk, rst_n, 1'b1, $onehot0(hit_r), "value matched in more than one slot")
  `ASSERT_NEXT(a_cnt_hold, clk, rst_n, !cmd.execute, $stable(count_r), "set size changed without a command")

endmodule

@@ rtl/bounded_unordered_set_store_top.sv @@
`timescale 1ns / 1ps
// Set of distinct 32-bit signed values kept in an unordered register store.
// Input channel: in_valid/in_stall with in_cmd (add, remove, query, clear)
// and in_value. Result channel: out_valid/out_stall with out_was_present,
// out_position, out_set_size, out_stored and out_rejected_full; exactly one
// result beat per input beat, in order.
// Configuration: cfg_wr_en/cfg_wr_data write capacity_limit;
// write it only while no command is in flight.
// Timing: a command is accepted in idle, and all slots are compared against its
// value into the compare register; once the result register is free, the
// update is applied and the result register loaded. A new command is taken
// only after the previous one has been applied, as the compare register is
// followed by the update step for each command.
// A stalled result holds; while it holds, the pending command waits and
// in_stall stays high, so nothing is dropped.
// Reset (rst_n low, synchronous) empties the set, sets the capacity to 16
// and drops any result beat. Usable slots are min(DEPTH, 31).
module bounded_unordered_set_store_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_was_present,
  output logic [3:0]         out_position,
  output logic [4:0]         out_set_size,
  output logic               out_stored,
  output logic               out_rejected_full,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data
);

  uset_pkg::uset_cmd_t cmd;

  uset_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  uset_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_cmd            (in_cmd),
    .in_value          (in_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_was_present   (out_was_present),
    .out_position      (out_position),
    .out_set_size      (out_set_size),
    .out_stored        (out_stored),
    .out_rejected_full (out_rejected_full)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  localparam int DEPTH       = 16;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES  = 10;

  typedef struct packed {
    logic       was_present;
    logic [3:0] position;
    logic [4:0] set_size;
    logic       stored;
    logic       rejected_full;
  } set_result_t;

  // mirror of the set contents; predicts one result per command
  class uset_scoreboard;
    logic [31:0] slots [DEPTH];
    int          count;
    int          cap;
    set_result_t pending[$];
    int          mismatches;
    int          checked;
    int          n_stored;
    int          n_full;
    int          n_hits;

    function new();
      count      = 0;
      cap        = uset_pkg::CAP_RESET;
      mismatches = 0;
      checked    = 0;
      n_stored   = 0;
      n_full     = 0;
      n_hits     = 0;
    endfunction

    function void note_command(uset_pkg::uset_op_t op, logic [31:0] v);
      int          slot;
      int          lim;
      int          i;
      set_result_t r;
      slot = -1;
      r    = '0;
      lim  = (cap > DEPTH) ? DEPTH : cap;
      if (op == uset_pkg::OP_CLEAR) begin
        count = 0;
      end else begin
        for (i = 0; i < count; i++)
          if (slot < 0 && slots[i] == v) slot = i;
        if (slot >= 0) begin
          r.was_present = 1'b1;
          r.position    = slot[3:0];
        end
        if (op == uset_pkg::OP_ADD && slot < 0) begin
          if (count < lim) begin
            slots[count] = v;
            count++;
            r.stored = 1'b1;
          end else begin
            r.rejected_full = 1'b1;
          end
        end else if (op == uset_pkg::OP_REMOVE && slot >= 0) begin
          // last entry fills the hole
          count--;
          slots[slot] = slots[count];
        end
      end
      r.set_size = count[4:0];
      pending.push_back(r);
    endfunction

    function void check_result(set_result_t got);
      set_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: present=%0b pos=%0d size=%0d %s%0b full=%0b",
                   got.was_present, got.position, got.set_size, "stored=",
                   got.stored, got.rejected_full);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.stored) n_stored++;
      if (want.rejected_full) n_full++;
      if (want.was_present) n_hits++;
      if (got.was_present !== want.was_present || got.position !== want.position ||
          got.set_size !== want.set_size || got.stored !== want.stored ||
          got.rejected_full !== want.rejected_full) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected present=%0b pos=%0d size=%0d %s%0b full=%0b",
                   $time, want.was_present, want.position, want.set_size, "stored=",
                   want.stored, want.rejected_full);
          $display("  got present=%0b pos=%0d size=%0d stored=%0b full=%0b",
                   got.was_present, got.position, got.set_size, got.stored,
                   got.rejected_full);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_cmd;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic               out_was_present;
  logic [3:0]         out_position;
  logic [4:0]         out_set_size;
  logic               out_stored;
  logic               out_rejected_full;
  logic               cfg_wr_en;
  logic [4:0]         cfg_wr_data;

  logic hold_req = 1'b0;
  logic calm     = 1'b0;
  int   sent     = 0;
  int   n_settings = 0;

  uset_scoreboard sb = new();

  bounded_unordered_set_store_top #(.DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_was_present  (out_was_present),
    .out_position     (out_position),
    .out_set_size     (out_set_size),
    .out_stored       (out_stored),
    .out_rejected_full(out_rejected_full),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // both channels sampled on the edge, before any update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result({out_was_present, out_position, out_set_size, out_stored,
                         out_rejected_full});
      if (in_valid && !in_stall)
        sb.note_command(uset_pkg::uset_op_t'(in_cmd), in_value);
    end
  end

  // result side: random stalls, or one long hold when asked
  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 30);
      end
    end
  end

  task automatic send_cmd(uset_pkg::uset_op_t op, logic [31:0] v);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= op;
    in_value <= v;
    sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] c);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.cap = c;
    n_settings++;
  endtask

  initial begin
    logic [4:0]         caps [NUM_PHASES];
    logic [31:0]        pool [24];
    int                 pool_n;
    int                 lim;
    int                 p;
    int                 n;
    int                 r;
    uset_pkg::uset_op_t op;
    logic [31:0]        v;

    caps = '{5'd0, 5'd16, 5'd31, 5'd5, 5'd16, 5'd1, 5'd12, 5'd3, 5'd31, 5'd9};
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_cmd      <= uset_pkg::OP_QUERY;
    in_value    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small capacity: empty set, duplicates, full, swap on remove, clear
    write_capacity(5'd2);
    send_cmd(uset_pkg::OP_QUERY, 32'h0000_0000);
    send_cmd(uset_pkg::OP_REMOVE, 32'h0000_0005);
    send_cmd(uset_pkg::OP_ADD, 32'h8000_0000);
    send_cmd(uset_pkg::OP_ADD, 32'h7fff_ffff);
    send_cmd(uset_pkg::OP_ADD, 32'h8000_0000);
    send_cmd(uset_pkg::OP_ADD, 32'h7fff_ffff);
    send_cmd(uset_pkg::OP_ADD, 32'hffff_ffff);
    send_cmd(uset_pkg::OP_QUERY, 32'h7fff_ffff);
    send_cmd(uset_pkg::OP_REMOVE, 32'h8000_0000);
    send_cmd(uset_pkg::OP_QUERY, 32'h7fff_ffff);
    send_cmd(uset_pkg::OP_ADD, 32'h0000_0000);
    send_cmd(uset_pkg::OP_CLEAR, 32'ha5a5_5a5a);
    send_cmd(uset_pkg::OP_QUERY, 32'h0000_0000);
    wait_drained();

    // capacity beyond the store, then lowered under the current size
    write_capacity(5'd31);
    send_cmd(uset_pkg::OP_ADD, 32'd7);
    send_cmd(uset_pkg::OP_ADD, -32'sd7);
    send_cmd(uset_pkg::OP_ADD, 32'd100);
    wait_drained();
    write_capacity(5'd1);
    send_cmd(uset_pkg::OP_ADD, 32'd8);
    send_cmd(uset_pkg::OP_QUERY, -32'sd7);
    send_cmd(uset_pkg::OP_REMOVE, 32'd7);
    send_cmd(uset_pkg::OP_ADD, 32'd8);
    send_cmd(uset_pkg::OP_REMOVE, 32'd100);
    send_cmd(uset_pkg::OP_REMOVE, -32'sd7);
    send_cmd(uset_pkg::OP_ADD, 32'd8);

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_capacity(caps[p]);
      calm <= (p == 4);
      // a small pool of values keeps hits and full-set refusals frequent
      lim    = (caps[p] > DEPTH) ? DEPTH : caps[p];
      pool_n = lim + $urandom_range(1, 6);
      for (n = 0; n < pool_n; n++) pool[n] = $urandom;
      pool[$urandom_range(pool_n - 1)] = 32'h8000_0000;
      pool[$urandom_range(pool_n - 1)] = 32'h7fff_ffff;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 40) hold_req <= 1'b1;
        r = $urandom_range(99);
        if (r < 40) op = uset_pkg::OP_ADD;
        else if (r < 65) op = uset_pkg::OP_REMOVE;
        else if (r < 97) op = uset_pkg::OP_QUERY;
        else op = uset_pkg::OP_CLEAR;
        v = ($urandom_range(99) < 6) ? $urandom : pool[$urandom_range(pool_n - 1)];
        send_cmd(op, v);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("ran %0d commands over %0d capacity settings, %0d results checked",
             sent, n_settings, sb.checked);
    $display("  %0d values stored, %0d adds refused as full, %0d lookups found a value",
             sb.n_stored, sb.n_full, sb.n_hits);
    if (sb.pending.size() != 0)
      $display("%0d results never arrived", sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
